### hdl/rgb_to_hsv_pixel_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RGB to HSV pixel core
// Clocked, reset-qualified assertion helpers.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_CORE_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_CORE_ASSERT_SVH

// implication checked every clock edge outside reset
`define HSV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define HSV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/hsv_pkg.sv
// ---------------------------------------------------------------------------
// RGB to HSV package
// Widths, divider cell count and the stage record passed along the divider chain.
// ---------------------------------------------------------------------------
package hsv_pkg;

   localparam int ChanW  = 8;
   localparam int FracW  = 16;
   localparam int DenW   = 11;            // 6*C up to 1530
   localparam int RemW   = DenW + 1;
   localparam int NumCells = FracW;       // one quotient bit per cell
   localparam int QW     = NumCells;

   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [QW-1:0]   quo;
      logic [DenW-1:0] den;
   } div_lane_type;

   typedef struct packed {
      logic            valid;
      div_lane_type    hue;
      div_lane_type    sat;
      logic [ChanW-1:0] val;
   } hsv_stage_type;

endpackage

### hdl/hsv_front.sv
// ---------------------------------------------------------------------------
// RGB to HSV front end
// Finds max, chroma, sector numerator and denominators; registers them.
// ---------------------------------------------------------------------------
module hsv_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [hsv_pkg::ChanW-1:0] red,
   input  logic [hsv_pkg::ChanW-1:0] green,
   input  logic [hsv_pkg::ChanW-1:0] blue,
   output hsv_pkg::hsv_stage_type    stage_out
);
   logic [hsv_pkg::ChanW-1:0] vmax, vmin, chroma;
   logic [hsv_pkg::DenW-1:0]  num, den6;
   hsv_pkg::hsv_stage_type    stage_in, stage_ff;

   always_comb begin
      vmax = (red > green) ? red : green;
      if (blue > vmax) vmax = blue;
      vmin = (red < green) ? red : green;
      if (blue < vmin) vmin = blue;
      chroma = vmax - vmin;
      den6 = hsv_pkg::DenW'(6 * chroma);
      if (vmax == blue) begin
         num = hsv_pkg::DenW'(red) + hsv_pkg::DenW'({chroma, 2'b00}) - hsv_pkg::DenW'(green);
      end else if (vmax == green) begin
         num = hsv_pkg::DenW'(blue) + hsv_pkg::DenW'({chroma, 1'b0}) - hsv_pkg::DenW'(red);
      end else if (green >= blue) begin
         num = hsv_pkg::DenW'(green) - hsv_pkg::DenW'(blue);
      end else begin
         num = den6 + hsv_pkg::DenW'(green) - hsv_pkg::DenW'(blue);
      end
      stage_in.valid   = in_valid;
      stage_in.val     = vmax;
      stage_in.hue.rem = hsv_pkg::RemW'(num);
      stage_in.hue.quo = '0;
      stage_in.hue.den = den6;
      // numerator scaled by 65535 = (C << 16) - C, quotient < 65536
      stage_in.sat.rem = hsv_pkg::RemW'(chroma);
      stage_in.sat.quo = '0;
      stage_in.sat.den = hsv_pkg::DenW'(vmax);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   // payload bits need no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.val <= stage_in.val;
         stage_ff.hue <= stage_in.hue;
         stage_ff.sat <= stage_in.sat;
      end
   end

   assign stage_out = stage_ff;
endmodule

### hdl/hsv_div_cell.sv
// ---------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring division step for hue and saturation lanes, registered.
// ---------------------------------------------------------------------------
module hsv_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  hsv_pkg::hsv_stage_type stage_in_d,
   output hsv_pkg::hsv_stage_type stage_out
);
   hsv_pkg::hsv_stage_type stage_in, stage_ff;
   logic [hsv_pkg::RemW:0] htry, strial;

   always_comb begin
      stage_in = stage_in_d;
      htry = {stage_in_d.hue.rem, 1'b0};
      if (htry >= {2'b00, stage_in_d.hue.den}) begin
         stage_in.hue.rem = hsv_pkg::RemW'(htry - {2'b00, stage_in_d.hue.den});
         stage_in.hue.quo = {stage_in_d.hue.quo[hsv_pkg::QW-2:0], 1'b1};
      end else begin
         stage_in.hue.rem = hsv_pkg::RemW'(htry);
         stage_in.hue.quo = {stage_in_d.hue.quo[hsv_pkg::QW-2:0], 1'b0};
      end
      strial = {stage_in_d.sat.rem, 1'b0};
      if (strial >= {2'b00, stage_in_d.sat.den}) begin
         stage_in.sat.rem = hsv_pkg::RemW'(strial - {2'b00, stage_in_d.sat.den});
         stage_in.sat.quo = {stage_in_d.sat.quo[hsv_pkg::QW-2:0], 1'b1};
      end else begin
         stage_in.sat.rem = hsv_pkg::RemW'(strial);
         stage_in.sat.quo = {stage_in_d.sat.quo[hsv_pkg::QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.val <= stage_in.val;
         stage_ff.hue <= stage_in.hue;
         stage_ff.sat <= stage_in.sat;
      end
   end

   assign stage_out = stage_ff;
endmodule

### hdl/rgb_to_hsv_pixel_core.sv
// ---------------------------------------------------------------------------
// RGB to HSV pixel core
// Converts one 8-bit RGB pixel per clock, unless the output stalls, into 16-bit hue/saturation and 8-bit value.
// ---------------------------------------------------------------------------
// Pipeline: front stage, 16 divider cells and output stage; all of them hold
// while rsp_tready is low and the output register is full.
// Throughput: one pixel per cycle unless the output stalls; the divider cell chain sets the depth.
// Reset: synchronous, clears all valid bits; the pipe is empty after reset.
module rgb_to_hsv_pixel_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // hue[15:0], saturation[31:16], brightness[39:32]
);
`include "rgb_to_hsv_pixel_core_assert.svh"

   localparam int N = hsv_pkg::NumCells;

   hsv_pkg::hsv_stage_type chain [0:N];
   logic        advance;
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic [hsv_pkg::ChanW-1:0] c_pipe [0:N];
   logic [hsv_pkg::RemW-1:0]  rem_last;
   logic [hsv_pkg::QW-1:0]    sat_fix;

   // pipe moves whenever the output register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   hsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      hsv_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .stage_in_d (chain[i]),
         .stage_out  (chain[i+1])
      );
   end

   // sat quotient is floor(C*65536/V) with remainder in [0, V];
   // floor((C*65536 - C)/V) is one less when that remainder is below C
   assign c_pipe[0] = chain[0].sat.rem[hsv_pkg::ChanW-1:0];
   for (genvar j = 0; j < N; j++) begin : g_cpipe
      logic [hsv_pkg::ChanW-1:0] c_ff;
      always_ff @(posedge clock) begin
         if (advance) c_ff <= c_pipe[j];
      end
      assign c_pipe[j+1] = c_ff;
   end
   assign rem_last = chain[N].sat.rem;
   always_comb begin
      sat_fix = chain[N].sat.quo;
      if (chain[N].sat.den == '0) begin
         sat_fix = '0;
      end else if (rem_last < hsv_pkg::RemW'(c_pipe[N])) begin
         sat_fix = chain[N].sat.quo - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[N].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {chain[N].val, sat_fix,
                         (chain[N].hue.den == '0) ? 16'h0000 : chain[N].hue.quo};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `HSV_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")
   `HSV_ASSERT_IMP(a_ready, clock, reset, !rsp_tvalid, req_tready, "input stalled with empty output")
   `HSV_ASSERT_IMP(a_black, clock, reset, rsp_tvalid && rsp_tdata[39:32] == 8'd0, rsp_tdata[31:0] == 32'd0, "black pixel not zero")
endmodule

### bench/hsv_pixel_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// HSV pixel checker
// Watches both stream channels of the RGB to HSV core, computes the expected
// hue, saturation and value for every accepted request and compares results
// in order.
// ---------------------------------------------------------------------------
module hsv_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count,
   output int          pixel_count
);

   typedef struct packed {
      logic [7:0]  val;
      logic [15:0] sat;
      logic [15:0] hue;
   } hsv_pixel_t;

   hsv_pixel_t hsv_queue[$];

   function automatic hsv_pixel_t convert_pixel(logic [23:0] rgb);
      int unsigned r, g, b, v, mn, c, num, h;
      hsv_pixel_t px;
      r = rgb[7:0];
      g = rgb[15:8];
      b = rgb[23:16];
      v = r > g ? r : g;
      v = v > b ? v : b;
      mn = r < g ? r : g;
      mn = mn < b ? mn : b;
      c = v - mn;
      px.val = v[7:0];
      px.sat = (v != 0) ? 16'((c * 65535) / v) : 16'd0;
      h = 0;
      if (c != 0) begin
         if (v == b) num = r + 4 * c - g;
         else if (v == g) num = b + 2 * c - r;
         else if (g >= b) num = g - b;
         else num = 6 * c + g - b;
         h = (num * 65536) / (6 * c);
         if (h > 65535) h = 65535;
      end
      px.hue = h[15:0];
      return px;
   endfunction

   assign pending_count = hsv_queue.size();

   always_ff @(posedge clock) begin
      hsv_pixel_t want, got;
      if (reset) begin
         fail_count <= 0;
         pixel_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            hsv_queue.push_back(convert_pixel(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[39:32], rsp_tdata[31:16], rsp_tdata[15:0]};
            pixel_count <= pixel_count + 1;
            if (hsv_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = hsv_queue.pop_front();
               if (want.hue !== got.hue)
                  $display("%0t: hue expected %h actual %h", $time, want.hue, got.hue);
               if (want.sat !== got.sat)
                  $display("%0t: saturation expected %h actual %h", $time, want.sat,
                     got.sat);
               if (want.val !== got.val)
                  $display("%0t: brightness expected %h actual %h", $time, want.val,
                     got.val);
               if (want !== got) fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

### bench/tb_rgb_to_hsv_pixel_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RGB to HSV pixel core testbench
// Drives directed and random pixels through the core under several idle and
// stall mixes, including a long output hold-off; a checker predicts results.
// ---------------------------------------------------------------------------
module tb_rgb_to_hsv_pixel_core;

   localparam int LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   int          fail_count, pending_count, pixel_count;
   int          send_idle, recv_stall;
   int          hold_cycles = 0;
   int          cycle_count = 0;
   logic        hold_go = 1'b0;
   logic        hold_used = 1'b0;

   rgb_to_hsv_pixel_core dut (.*);

   hsv_pixel_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_used <= 1'b1;
         hold_cycles <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, g, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic random_pixel();
      logic [7:0] r, g, b, base;
      base = $urandom;
      r = $urandom;
      g = $urandom;
      b = $urandom;
      case ($urandom_range(5))
         0: begin g = base; b = base; end
         1: r = g;
         2: g = b;
         3: begin r = $urandom_range(255, 250); g = $urandom_range(5); end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   initial begin
      send_idle = 0;
      recv_stall = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      send_pixel(0, 0, 0);
      send_pixel(255, 255, 255);
      send_pixel(128, 128, 128);
      send_pixel(255, 0, 0);
      send_pixel(0, 255, 0);
      send_pixel(0, 0, 255);
      send_pixel(255, 255, 0);
      send_pixel(0, 255, 255);
      send_pixel(255, 0, 255);
      send_pixel(255, 0, 1);
      send_pixel(255, 0, 254);
      send_pixel(1, 0, 0);
      send_pixel(0, 1, 0);
      send_pixel(0, 0, 1);
      send_pixel(255, 1, 0);
      send_pixel(1, 0, 1);
      send_pixel(170, 85, 85);
      send_pixel(8'haa, 8'h55, 8'h0f);
      send_pixel(8'h55, 8'haa, 8'hf0);
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 82; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 82; end
            3: begin send_idle = 37; recv_stall = 37; end
            default: begin send_idle = 0; recv_stall = 10; hold_go = 1'b1; end
         endcase
         for (int i = 0; i < 166; i++) random_pixel();
      end
      req_tvalid <= 1'b0;
      recv_stall = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Ran %0d pixels: directed extremes, then random pixels under idle,", pixel_count);
      $display("stall and long hold-off mixes.");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
